@@ design/clrp_pkg.sv @@
// Shared types and constants for the cache line replacement policy block.
package clrp_pkg;

  // Replacement mode codes; the spare code behaves as LRFU
  localparam logic [1:0] MODE_FIFO  = 2'd0;
  localparam logic [1:0] MODE_LRU   = 2'd1;
  localparam logic [1:0] MODE_LRFU  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Per-line use counter, saturating
  localparam int unsigned USES_W = 16;

  // Update broadcast to every line after a scan completes
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_HIT,
    ACT_FILL,
    ACT_EVICT
  } act_t;

endpackage

@@ design/clrp_cell.sv @@
// One line of the tag store: holds the line state and folds it into the passing scan token.
module clrp_cell
  import clrp_pkg::*;
#(
  parameter int unsigned LINES     = 8,
  parameter int unsigned TAG_WIDTH = 16,
  parameter int unsigned IDX       = 0,
  localparam int unsigned IDX_W    = $clog2(LINES),
  localparam int unsigned TOK_W    = 4 + 2 * TAG_WIDTH + 5 * IDX_W + USES_W,
  localparam int unsigned UPD_W    = 2 + 2 * IDX_W + TAG_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       mode,
  input  logic [TOK_W-1:0] tok_in,
  output logic [TOK_W-1:0] tok_out,
  input  logic [UPD_W-1:0] upd_in
);

  typedef struct packed {
    logic                 vld;
    logic [TAG_WIDTH-1:0] tag;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [IDX_W-1:0]     hit_rank;
    logic                 free;
    logic [IDX_W-1:0]     free_idx;
    logic                 vic;
    logic [IDX_W-1:0]     vic_idx;
    logic [IDX_W-1:0]     vic_rank;
    logic [USES_W-1:0]    vic_uses;
    logic [TAG_WIDTH-1:0] vic_tag;
  } tok_t;

  typedef struct packed {
    act_t                 act;
    logic [IDX_W-1:0]     idx;
    logic [IDX_W-1:0]     pivot;
    logic [TAG_WIDTH-1:0] tag;
  } upd_t;

  localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(IDX);
  localparam logic [IDX_W-1:0] TOP_RANK = IDX_W'(LINES - 1);

  logic                 valid_r,  valid_nxt;
  logic [TAG_WIDTH-1:0] tag_r,    tag_nxt;
  logic [IDX_W-1:0]     rank_r,   rank_nxt;
  logic [USES_W-1:0]    uses_r,   uses_nxt;
  tok_t                 tok_r,    tok_nxt;

  tok_t tin;
  upd_t upd;
  logic lrfu;
  logic better;
  logic me;
  logic aging;

  assign tin  = tok_t'(tok_in);
  assign upd  = upd_t'(upd_in);
  assign lrfu = (mode == MODE_LRFU) || (mode == MODE_SPARE);

  // Victim ordering: least rank, or least uses then least rank; strict compare keeps lowest index
  always_comb begin
    if (!tin.vic) begin
      better = 1'b1;
    end else if (lrfu) begin
      better = (uses_r < tin.vic_uses) ||
               ((uses_r == tin.vic_uses) && (rank_r < tin.vic_rank));
    end else begin
      better = rank_r < tin.vic_rank;
    end
  end

  // Fold this line into the token
  always_comb begin
    tok_nxt = tin;
    if (valid_r && (tag_r == tin.tag) && !tin.hit) begin
      tok_nxt.hit      = 1'b1;
      tok_nxt.hit_idx  = MY_IDX;
      tok_nxt.hit_rank = rank_r;
    end
    if (!valid_r && !tin.free) begin
      tok_nxt.free     = 1'b1;
      tok_nxt.free_idx = MY_IDX;
    end
    if (better) begin
      tok_nxt.vic      = 1'b1;
      tok_nxt.vic_idx  = MY_IDX;
      tok_nxt.vic_rank = rank_r;
      tok_nxt.vic_uses = uses_r;
      tok_nxt.vic_tag  = tag_r;
    end
  end

  // Line update from the broadcast decision
  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    rank_nxt  = rank_r;
    uses_nxt  = uses_r;
    me        = (upd.idx == MY_IDX);
    aging     = 1'b0;
    case (upd.act)
      ACT_HIT: begin
        if (me) begin
          if (uses_r != {USES_W{1'b1}}) begin
            uses_nxt = uses_r + USES_W'(1);
          end
          if (mode != MODE_FIFO) begin
            rank_nxt = TOP_RANK;
          end
        end else begin
          aging = (mode != MODE_FIFO);
        end
      end
      ACT_FILL: begin
        if (me) begin
          valid_nxt = 1'b1;
          tag_nxt   = upd.tag;
          uses_nxt  = USES_W'(1);
          rank_nxt  = MY_IDX;
        end
      end
      ACT_EVICT: begin
        if (me) begin
          tag_nxt  = upd.tag;
          uses_nxt = USES_W'(1);
          rank_nxt = TOP_RANK;
        end else begin
          aging = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (aging && (rank_r > upd.pivot)) begin
      rank_nxt = rank_r - IDX_W'(1);
    end
  end

  // Line state and token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      tok_r.vld <= tok_nxt.vld;
    end
    tag_r            <= tag_nxt;
    rank_r           <= rank_nxt;
    uses_r           <= uses_nxt;
    tok_r.tag        <= tok_nxt.tag;
    tok_r.hit        <= tok_nxt.hit;
    tok_r.hit_idx    <= tok_nxt.hit_idx;
    tok_r.hit_rank   <= tok_nxt.hit_rank;
    tok_r.free       <= tok_nxt.free;
    tok_r.free_idx   <= tok_nxt.free_idx;
    tok_r.vic        <= tok_nxt.vic;
    tok_r.vic_idx    <= tok_nxt.vic_idx;
    tok_r.vic_rank   <= tok_nxt.vic_rank;
    tok_r.vic_uses   <= tok_nxt.vic_uses;
    tok_r.vic_tag    <= tok_nxt.vic_tag;
  end

  assign tok_out = tok_r;

endmodule

@@ design/cache_line_replacement_policy.sv @@
// Fully associative tag store with FIFO / LRU / LRFU replacement, built as a chain of line cells.
// An accepted request's scan token is registered in each cell of the chain in turn, and the
//   result beat is registered once the token leaves the last cell.
// One request at a time: the scan token walks the cell chain one line per cycle, and the
//   next request waits until the result beat is taken.
// Reset (rst_n low, synchronous): all lines invalid, mode FIFO, no request in flight.
module cache_line_replacement_policy
  import clrp_pkg::*;
#(
  parameter int unsigned LINES     = 8,
  parameter int unsigned TAG_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [TAG_WIDTH-1:0]       in_lookup_tag,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_hit,
  output logic [$clog2(LINES)-1:0]   out_line_index,
  output logic                       out_evicted,
  output logic [TAG_WIDTH-1:0]       out_evicted_tag
);

  localparam int unsigned IDX_W = $clog2(LINES);

  typedef struct packed {
    logic                 vld;
    logic [TAG_WIDTH-1:0] tag;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [IDX_W-1:0]     hit_rank;
    logic                 free;
    logic [IDX_W-1:0]     free_idx;
    logic                 vic;
    logic [IDX_W-1:0]     vic_idx;
    logic [IDX_W-1:0]     vic_rank;
    logic [USES_W-1:0]    vic_uses;
    logic [TAG_WIDTH-1:0] vic_tag;
  } tok_t;

  typedef struct packed {
    act_t                 act;
    logic [IDX_W-1:0]     idx;
    logic [IDX_W-1:0]     pivot;
    logic [TAG_WIDTH-1:0] tag;
  } upd_t;

  logic [1:0]           mode_r;
  logic                 busy_r,      busy_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 hit_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 evicted_r;
  logic [TAG_WIDTH-1:0] evicted_tag_r;

  logic in_acc;
  logic out_acc;
  tok_t seed;
  tok_t tail;
  upd_t upd;
  tok_t chain [LINES+1];

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign in_stall = busy_r || out_valid_r;

  // Fresh token for an accepted request
  always_comb begin
    seed     = '0;
    seed.vld = in_acc;
    seed.tag = in_lookup_tag;
  end

  assign chain[0] = seed;

  // Cell chain, one cell per line
  for (genvar g = 0; g < LINES; g++) begin : g_line
    clrp_cell #(
      .LINES     (LINES),
      .TAG_WIDTH (TAG_WIDTH),
      .IDX       (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .mode    (mode_r),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1]),
      .upd_in  (upd)
    );
  end

  assign tail = chain[LINES];

  // Decision once the token leaves the last cell; the tag rides along to every line
  always_comb begin
    upd = '0;
    if (tail.vld) begin
      upd.tag = tail.tag;
      if (tail.hit) begin
        upd.act   = ACT_HIT;
        upd.idx   = tail.hit_idx;
        upd.pivot = tail.hit_rank;
      end else if (tail.free) begin
        upd.act   = ACT_FILL;
        upd.idx   = tail.free_idx;
      end else begin
        upd.act   = ACT_EVICT;
        upd.idx   = tail.vic_idx;
        upd.pivot = tail.vic_rank;
      end
    end
  end

  // Control next state
  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
    end
    if (tail.vld) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end else if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control, config and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_FIFO;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
    if (tail.vld) begin
      hit_r         <= tail.hit;
      evicted_r     <= !tail.hit && !tail.free;
      evicted_tag_r <= (!tail.hit && !tail.free) ? tail.vic_tag : '0;
      idx_r         <= upd.idx;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = hit_r;
  assign out_line_index  = idx_r;
  assign out_evicted     = evicted_r;
  assign out_evicted_tag = evicted_tag_r;

endmodule

@@ design/clrp_checker.sv @@
// Port-level assertions for the cache line replacement policy, bound to the top level.
module clrp_checker #(
  parameter int unsigned LINES     = 8,
  parameter int unsigned TAG_WIDTH = 16
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     cfg_we,
  input logic [1:0]               cfg_wdata,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [TAG_WIDTH-1:0]     in_lookup_tag,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     out_hit,
  input logic [$clog2(LINES)-1:0] out_line_index,
  input logic                     out_evicted,
  input logic [TAG_WIDTH-1:0]     out_evicted_tag
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_line_index) &&
      $stable(out_hit) && $stable(out_evicted) && $stable(out_evicted_tag))
    else $error("stalled result beat changed");

  // One request at a time: an accepted beat blocks the next cycle
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another in flight");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted)
    else $error("hit reported with eviction");

  // Evicted tag reads zero when nothing was evicted
  a_evict_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> out_evicted_tag == '0)
    else $error("evicted tag nonzero without eviction");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind cache_line_replacement_policy clrp_checker #(
  .LINES     (LINES),
  .TAG_WIDTH (TAG_WIDTH)
) u_clrp_checker (.*);

@@ sim/cache_line_replacement_policy_tb.sv @@
// Self-checking testbench: directed and random lookups checked against typed results or a line-store predictor.
`timescale 1ns / 100ps

module cache_line_replacement_policy_tb;
  import clrp_pkg::*;

  localparam int LINE_CNT = 8;
  localparam int TAG_W = 16;
  localparam logic [2:0] TOP_RANK = 3'(LINE_CNT - 1);
  localparam logic [15:0] USES_CAP = 16'hFFFF;
  localparam int STALL_LIMIT = 1000;   // cycles with no beat on either channel
  localparam int TAIL_CYCLES = 20;     // settle time after the last result
  localparam int PHASE_ITEMS = 155;

  typedef struct packed {
    logic              hit;
    logic [2:0]        idx;
    logic              evicted;
    logic [TAG_W-1:0]  evicted_tag;
  } lookup_res_t;

  typedef struct {
    logic [1:0]        mode;
    logic [TAG_W-1:0]  tag;
    bit                typed;
    lookup_res_t       want;
  } probe_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = MODE_FIFO;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TAG_W-1:0] in_lookup_tag = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic out_hit;
  logic [2:0] out_line_index;
  logic out_evicted;
  logic [TAG_W-1:0] out_evicted_tag;

  // Shadow copy of the tag store
  logic             shadow_valid [LINE_CNT];
  logic [TAG_W-1:0] shadow_tag   [LINE_CNT];
  logic [2:0]       shadow_rank  [LINE_CNT];
  logic [15:0]      shadow_uses  [LINE_CNT];
  logic [1:0]       policy = MODE_FIFO;

  lookup_res_t pending_lookups[$];
  probe_row_t  probe_rows[$];
  logic [TAG_W-1:0] hot_tags[16];
  logic [1:0] phase_modes[6];

  bit quiet = 1'b0;
  int mismatches = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  lookup_res_t oldest;

  cache_line_replacement_policy #(
    .LINES(LINE_CNT),
    .TAG_WIDTH(TAG_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_lookup_tag(in_lookup_tag),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_hit(out_hit),
    .out_line_index(out_line_index),
    .out_evicted(out_evicted),
    .out_evicted_tag(out_evicted_tag)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Lines ranked above the pivot move one step toward the oldest rank
  function automatic void age_ranks_above(input logic [2:0] pivot);
    for (int i = 0; i < LINE_CNT; i++) begin
      if (shadow_rank[i] > pivot) shadow_rank[i] = shadow_rank[i] - 3'd1;
    end
  endfunction

  // Applies one lookup to the shadow store and returns the expected beat
  function automatic lookup_res_t predict_lookup(input logic [TAG_W-1:0] tag);
    lookup_res_t r;
    int slot;
    bit by_uses;
    logic [15:0] least_uses;
    r = '0;
    slot = -1;
    for (int i = 0; i < LINE_CNT; i++) begin
      if (slot < 0 && shadow_valid[i] && shadow_tag[i] == tag) slot = i;
    end
    if (slot >= 0) begin
      // hit: count saturates, recency moves only outside FIFO
      r.hit = 1'b1;
      if (shadow_uses[slot] != USES_CAP) shadow_uses[slot] = shadow_uses[slot] + 16'd1;
      if (policy != MODE_FIFO) begin
        age_ranks_above(shadow_rank[slot]);
        shadow_rank[slot] = TOP_RANK;
      end
    end else begin
      for (int i = 0; i < LINE_CNT; i++) begin
        if (slot < 0 && !shadow_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        // free line: rank follows its index
        shadow_valid[slot] = 1'b1;
        shadow_tag[slot] = tag;
        shadow_uses[slot] = 16'd1;
        shadow_rank[slot] = 3'(slot);
      end else begin
        // full store: oldest line, among the least used ones under LRFU
        by_uses = (policy == MODE_LRFU || policy == MODE_SPARE);
        least_uses = USES_CAP;
        if (by_uses) begin
          for (int i = 0; i < LINE_CNT; i++) begin
            if (shadow_uses[i] < least_uses) least_uses = shadow_uses[i];
          end
        end
        for (int i = 0; i < LINE_CNT; i++) begin
          if (!(by_uses && shadow_uses[i] != least_uses)) begin
            if (slot < 0 || shadow_rank[i] < shadow_rank[slot]) slot = i;
          end
        end
        r.evicted = 1'b1;
        r.evicted_tag = shadow_tag[slot];
        age_ranks_above(shadow_rank[slot]);
        shadow_tag[slot] = tag;
        shadow_uses[slot] = 16'd1;
        shadow_rank[slot] = TOP_RANK;
      end
    end
    r.idx = 3'(slot);
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] mode, input logic [TAG_W-1:0] tag,
                                  input bit typed, input logic hit, input logic [2:0] idx,
                                  input logic evicted, input logic [TAG_W-1:0] evicted_tag);
    probe_row_t row;
    row.mode = mode;
    row.tag = tag;
    row.typed = typed;
    row.want = '{hit, idx, evicted, evicted_tag};
    probe_rows.push_back(row);
  endfunction

  // Drops valid, waits for the block to drain, then writes the policy register
  task automatic set_policy(input logic [1:0] mode);
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    policy = mode;
  endtask

  // Sends one request beat after a random gap and records its expected result
  task automatic send_lookup(input logic [TAG_W-1:0] tag, input bit typed,
                             input lookup_res_t typed_res);
    int gap;
    lookup_res_t r;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_lookup_tag <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_lookup(tag);
    pending_lookups.push_back(typed ? typed_res : r);
  endtask

  // Result side: random stall per beat, compare against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      if (pending_lookups.size() == 0) begin
        $error("result beat with no request outstanding: line %0d", out_line_index);
        mismatches++;
      end else begin
        oldest = pending_lookups.pop_front();
        if (out_hit !== oldest.hit) begin
          $error("hit: expected %0d, got %0d", oldest.hit, out_hit);
          mismatches++;
        end
        if (out_line_index !== oldest.idx) begin
          $error("line_index: expected %0d, got %0d", oldest.idx, out_line_index);
          mismatches++;
        end
        if (out_evicted !== oldest.evicted) begin
          $error("evicted: expected %0d, got %0d", oldest.evicted, out_evicted);
          mismatches++;
        end
        if (out_evicted_tag !== oldest.evicted_tag) begin
          $error("evicted_tag: expected %h, got %h", oldest.evicted_tag, out_evicted_tag);
          mismatches++;
        end
      end
      stall_left = quiet ? 0 : $urandom_range(0, 4);
      out_stall <= (stall_left != 0);
    end else if (out_valid && out_stall) begin
      stall_left--;
      if (stall_left <= 0) out_stall <= 1'b0;
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int sel;
    int pool_n;
    logic [TAG_W-1:0] tag;

    for (int i = 0; i < LINE_CNT; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_tag[i] = '0;
      shadow_rank[i] = '0;
      shadow_uses[i] = '0;
    end

    // Directed: fill from empty, hits, FIFO evictions, then the other policies
    add_row(MODE_FIFO, 16'h0000, 1, 1'b0, 3'd0, 1'b0, 16'h0000);  // zero tag misses after reset
    add_row(MODE_FIFO, 16'hFFFF, 1, 1'b0, 3'd1, 1'b0, 16'h0000);
    add_row(MODE_FIFO, 16'h0000, 1, 1'b1, 3'd0, 1'b0, 16'h0000);
    add_row(MODE_FIFO, 16'hFFFF, 1, 1'b1, 3'd1, 1'b0, 16'h0000);
    add_row(MODE_FIFO, 16'h0001, 1, 1'b0, 3'd2, 1'b0, 16'h0000);
    add_row(MODE_FIFO, 16'h8000, 1, 1'b0, 3'd3, 1'b0, 16'h0000);
    add_row(MODE_FIFO, 16'h00FF, 1, 1'b0, 3'd4, 1'b0, 16'h0000);
    add_row(MODE_FIFO, 16'hFF00, 1, 1'b0, 3'd5, 1'b0, 16'h0000);
    add_row(MODE_FIFO, 16'h5555, 1, 1'b0, 3'd6, 1'b0, 16'h0000);
    add_row(MODE_FIFO, 16'hAAAA, 1, 1'b0, 3'd7, 1'b0, 16'h0000);
    add_row(MODE_FIFO, 16'h1234, 1, 1'b0, 3'd0, 1'b1, 16'h0000);  // oldest fill goes first
    add_row(MODE_FIFO, 16'h4321, 1, 1'b0, 3'd1, 1'b1, 16'hFFFF);
    add_row(MODE_FIFO, 16'hFFFF, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
    add_row(MODE_FIFO, 16'h1234, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
    add_row(MODE_LRU,  16'h5555, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
    add_row(MODE_LRU,  16'h8000, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
    add_row(MODE_LRU,  16'h7777, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
    add_row(MODE_LRU,  16'h7778, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
    add_row(MODE_LRFU, 16'h7777, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
    add_row(MODE_LRFU, 16'h7777, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
    add_row(MODE_LRFU, 16'h0F0F, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
    add_row(MODE_LRFU, 16'hF0F0, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
    add_row(MODE_SPARE, 16'h3C3C, 0, 1'b0, 3'd0, 1'b0, 16'h0000);
    add_row(MODE_SPARE, 16'hC3C3, 0, 1'b0, 3'd0, 1'b0, 16'h0000);

    phase_modes[0] = MODE_LRU;
    phase_modes[1] = MODE_LRFU;
    phase_modes[2] = MODE_FIFO;
    phase_modes[3] = MODE_SPARE;
    phase_modes[4] = MODE_LRFU;
    phase_modes[5] = MODE_LRU;

    // Reset
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    set_policy(MODE_FIFO);

    foreach (probe_rows[r]) begin
      if (probe_rows[r].mode != policy) set_policy(probe_rows[r].mode);
      send_lookup(probe_rows[r].tag, probe_rows[r].typed, probe_rows[r].want);
    end

    // Random phases: a small hot set keeps hits and evictions frequent
    foreach (phase_modes[p]) begin
      set_policy(phase_modes[p]);
      pool_n = $urandom_range(9, 14);
      for (int i = 0; i < pool_n; i++) hot_tags[i] = TAG_W'($urandom);
      hot_tags[0] = p[0] ? 16'hFFFF : 16'h0000;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        sel = $urandom_range(0, 99);
        if (sel < 12) tag = TAG_W'($urandom);
        else if (sel < 50) tag = hot_tags[$urandom_range(0, 3)];
        else tag = hot_tags[$urandom_range(0, pool_n - 1)];
        if (sel == 99) hot_tags[$urandom_range(0, pool_n - 1)] = TAG_W'($urandom);
        send_lookup(tag, 0, '0);
      end
    end

    // Drain and settle
    in_valid <= 1'b0;
    quiet = 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/clrp_pkg.sv
design/clrp_cell.sv
design/cache_line_replacement_policy.sv
design/clrp_checker.sv
sim/cache_line_replacement_policy_tb.sv
